/* rtl/ddlr_pkg.sv */
// ----------------------------------------------------------------------------
// ddlr_pkg
// shared constants, codes and the cell payload type of the light ramp block
// ----------------------------------------------------------------------------
package ddlr_pkg;

    localparam int MAX_RELAYS = 4;

    localparam int MINUTE_W  = 11;
    localparam int RELAY_W   = 8;
    localparam int MASK_W    = 4;
    localparam int PCT_W     = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 11;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 16;

    // relay count width, quotient bits per division (one per cell)
    localparam int N_W   = $clog2(MAX_RELAYS + 1);
    localparam int QW    = (PCT_W > N_W) ? PCT_W : N_W;
    // remainder width covers 200*num + den and (n+1)*den
    localparam int REM_W = MINUTE_W + QW + 1;

    localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

    localparam logic [CFG_IDX_W-1:0] CFG_DAWN_START = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DAWN_END   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_DUSK_START = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_DUSK_END   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_RELAYS     = CFG_IDX_W'(4);

    localparam logic [MINUTE_W-1:0] RST_DAWN_START = MINUTE_W'(360);
    localparam logic [MINUTE_W-1:0] RST_DAWN_END   = MINUTE_W'(420);
    localparam logic [MINUTE_W-1:0] RST_DUSK_START = MINUTE_W'(1200);
    localparam logic [MINUTE_W-1:0] RST_DUSK_END   = MINUTE_W'(1260);
    localparam logic [RELAY_W-1:0]  RST_RELAYS     = RELAY_W'(4);

    typedef enum logic [1:0] {
        MODE_OFF,
        MODE_FULL,
        MODE_DAWN,
        MODE_DUSK
    } mode_t;

    typedef struct packed {
        logic [MINUTE_W-1:0] rise_begin;
        logic [MINUTE_W-1:0] rise_done;
        logic [MINUTE_W-1:0] fall_begin;
        logic [MINUTE_W-1:0] fall_done;
        logic [RELAY_W-1:0]  relays;
    } cfg_t;

    // a: relay ceiling division, b: brightness rounding division
    typedef struct packed {
        mode_t            mode;
        logic [N_W-1:0]   n;
        logic [REM_W-1:0] rem_a;
        logic [REM_W-1:0] dv_a;
        logic [QW-1:0]    q_a;
        logic [REM_W-1:0] rem_b;
        logic [REM_W-1:0] dv_b;
        logic [QW-1:0]    q_b;
    } cell_t;

endpackage

/* rtl/dawn_dusk_light_ramp_top.sv */
// ----------------------------------------------------------------------------
// dawn_dusk_light_ramp_top
// daylight ramp: relay stage mask and brightness percent per minute of day
// ----------------------------------------------------------------------------
// channel   direction  handshake                fields
// s_        in         s_tvalid / s_tready      tdata: minute_of_day
// m_        out        m_tvalid / m_tready      tdata: relay_mask, brightness_percent
// cfg_      in         cfg_wen                  cfg_index, cfg_wdata
//
// one item per cycle while the output is not stalled, registered in order in:
// setup stage, one cell per quotient bit of the shared division chain, output stage
// reset loads the default windows and empties every stage
// each stage holds its item while the next one is full and cannot hand on, so stalls fill bubbles first
// ----------------------------------------------------------------------------
module dawn_dusk_light_ramp_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ddlr_pkg::S_DATA_W-1:0]  s_tdata,   // [10:0] minute_of_day
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [3:0] relay_mask, [10:4] brightness_percent
    output logic [ddlr_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                           cfg_wen,
    input  logic [ddlr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ddlr_pkg::CFG_DAT_W-1:0] cfg_wdata
);
    import ddlr_pkg::*;

    cfg_t              cfg_reg;
    logic              c_valid [QW+1];
    logic              c_ready [QW+1];
    cell_t             c_data  [QW+1];
    logic [MASK_W-1:0] mask;
    logic [PCT_W-1:0]  pct;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rise_begin <= RST_DAWN_START;
            cfg_reg.rise_done  <= RST_DAWN_END;
            cfg_reg.fall_begin <= RST_DUSK_START;
            cfg_reg.fall_done  <= RST_DUSK_END;
            cfg_reg.relays     <= RST_RELAYS;
        end else if (cfg_wen) begin
            case (cfg_index)
                CFG_DAWN_START: cfg_reg.rise_begin <= cfg_wdata[MINUTE_W-1:0];
                CFG_DAWN_END:   cfg_reg.rise_done  <= cfg_wdata[MINUTE_W-1:0];
                CFG_DUSK_START: cfg_reg.fall_begin <= cfg_wdata[MINUTE_W-1:0];
                CFG_DUSK_END:   cfg_reg.fall_done  <= cfg_wdata[MINUTE_W-1:0];
                CFG_RELAYS:     cfg_reg.relays     <= cfg_wdata[RELAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ddlr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_minute (s_tdata[MINUTE_W-1:0]),
        .in_ready  (s_tready),
        .out_valid (c_valid[0]),
        .out_data  (c_data[0]),
        .out_ready (c_ready[0])
    );

    for (genvar i = 0; i < QW; i++) begin : g_cell
        ddlr_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (c_valid[i]),
            .in_data   (c_data[i]),
            .in_ready  (c_ready[i]),
            .out_valid (c_valid[i+1]),
            .out_data  (c_data[i+1]),
            .out_ready (c_ready[i+1])
        );
    end

    ddlr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c_valid[QW]),
        .in_data   (c_data[QW]),
        .in_ready  (c_ready[QW]),
        .out_valid (m_tvalid),
        .out_mask  (mask),
        .out_pct   (pct),
        .out_ready (m_tready)
    );

    assign m_tdata = {(M_DATA_W - MASK_W - PCT_W)'(0), pct, mask};

endmodule

/* rtl/ddlr_front.sv */
// ----------------------------------------------------------------------------
// ddlr_front
// classifies the minute against the windows and sets up both divisions
// ----------------------------------------------------------------------------
module ddlr_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ddlr_pkg::cfg_t               cfg,
    input  logic                         in_valid,
    input  logic [ddlr_pkg::MINUTE_W-1:0] in_minute,
    output logic                         in_ready,
    output logic                         out_valid,
    output ddlr_pkg::cell_t              out_data,
    input  logic                         out_ready
);
    import ddlr_pkg::*;

    logic                valid_reg;
    cell_t               data_reg;
    cell_t               data_next;
    mode_t               mode;
    logic [N_W-1:0]      n;
    logic [MINUTE_W-1:0] num;
    logic [MINUTE_W-1:0] den;
    logic [MINUTE_W-1:0] frac;

    always_comb begin
        if (cfg.relays == RELAY_W'(0) || cfg.relays > RELAY_W'(MAX_RELAYS)) begin
            n = N_W'(MAX_RELAYS);
        end else begin
            n = cfg.relays[N_W-1:0];
        end

        if (in_minute < cfg.rise_begin || in_minute >= cfg.fall_done) begin
            mode = MODE_OFF;
        end else if (in_minute >= cfg.rise_done && in_minute < cfg.fall_begin) begin
            mode = MODE_FULL;
        end else if (in_minute < cfg.rise_done) begin
            mode = MODE_DAWN;
        end else begin
            mode = MODE_DUSK;
        end

        if (mode == MODE_DUSK) begin
            num  = in_minute - cfg.fall_begin;
            den  = cfg.fall_done - cfg.fall_begin;
            frac = den - num;
        end else begin
            num  = in_minute - cfg.rise_begin;
            den  = cfg.rise_done - cfg.rise_begin;
            frac = num;
        end

        data_next.mode  = mode;
        data_next.n     = n;
        data_next.rem_a = REM_W'(REM_W'(n) * REM_W'(num)) + REM_W'(den) - REM_W'(1);
        data_next.dv_a  = REM_W'(den) << (QW - 1);
        data_next.q_a   = '0;
        data_next.rem_b = REM_W'(REM_W'(200) * REM_W'(frac)) + REM_W'(den);
        data_next.dv_b  = REM_W'({den, 1'b0}) << (QW - 1);
        data_next.q_b   = '0;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

/* rtl/ddlr_cell.sv */
// ----------------------------------------------------------------------------
// ddlr_cell
// one restoring division step for both quotients, then hands on to the next
// ----------------------------------------------------------------------------
module ddlr_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  ddlr_pkg::cell_t in_data,
    output logic            in_ready,
    output logic            out_valid,
    output ddlr_pkg::cell_t out_data,
    input  logic            out_ready
);
    import ddlr_pkg::*;

    logic  valid_reg;
    cell_t data_reg;
    cell_t data_next;
    logic  take_a;
    logic  take_b;

    always_comb begin
        take_a    = in_data.rem_a >= in_data.dv_a;
        take_b    = in_data.rem_b >= in_data.dv_b;
        data_next = in_data;
        if (take_a) begin
            data_next.rem_a = in_data.rem_a - in_data.dv_a;
        end
        if (take_b) begin
            data_next.rem_b = in_data.rem_b - in_data.dv_b;
        end
        data_next.q_a  = {in_data.q_a[QW-2:0], take_a};
        data_next.q_b  = {in_data.q_b[QW-2:0], take_b};
        data_next.dv_a = in_data.dv_a >> 1;
        data_next.dv_b = in_data.dv_b >> 1;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

/* rtl/ddlr_back.sv */
// ----------------------------------------------------------------------------
// ddlr_back
// turns the quotients into the relay mask and brightness, output register
// ----------------------------------------------------------------------------
module ddlr_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    input  ddlr_pkg::cell_t            in_data,
    output logic                       in_ready,
    output logic                       out_valid,
    output logic [ddlr_pkg::MASK_W-1:0] out_mask,
    output logic [ddlr_pkg::PCT_W-1:0]  out_pct,
    input  logic                       out_ready
);
    import ddlr_pkg::*;

    logic              valid_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [PCT_W-1:0]  pct_reg;
    logic [MASK_W-1:0] mask_next;
    logic [PCT_W-1:0]  pct_next;
    logic [N_W-1:0]    active;
    logic [PCT_W-1:0]  pct_q;

    always_comb begin
        if (in_data.q_b > QW'(PCT_FULL)) begin
            pct_q = PCT_FULL;
        end else begin
            pct_q = in_data.q_b[PCT_W-1:0];
        end

        case (in_data.mode)
            MODE_OFF: begin
                active   = '0;
                pct_next = '0;
            end
            MODE_FULL: begin
                active   = in_data.n;
                pct_next = PCT_FULL;
            end
            MODE_DAWN: begin
                if (in_data.q_a > QW'(in_data.n)) begin
                    active = in_data.n;
                end else begin
                    active = in_data.q_a[N_W-1:0];
                end
                pct_next = pct_q;
            end
            MODE_DUSK: begin
                if (in_data.q_a >= QW'(in_data.n)) begin
                    active = '0;
                end else begin
                    active = in_data.n - in_data.q_a[N_W-1:0];
                end
                pct_next = pct_q;
            end
            default: begin
                active   = '0;
                pct_next = '0;
            end
        endcase

        for (int i = 0; i < MASK_W; i++) begin
            mask_next[i] = int'(active) > i;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_mask  = mask_reg;
    assign out_pct   = pct_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            mask_reg <= mask_next;
            pct_reg  <= pct_next;
        end
    end

endmodule

/* tb/tb_dawn_dusk_light_ramp_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dawn_dusk_light_ramp_top
// self-checking bench for the daylight ramp block
// ----------------------------------------------------------------------------
// minutes of the day stream in on the s_ channel; every accepted item is run
// through a local integer model of the dawn and dusk ramps using the window
// registers last written, and each m_ result is compared with the oldest
// predicted relay mask and brightness. directed items hit the window edges,
// empty and crossed windows and the relay count limits; random days follow
// with fresh window settings per phase, bursty input and a stalling sink.
// ----------------------------------------------------------------------------
module tb_dawn_dusk_light_ramp_top;
    import ddlr_pkg::*;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic [PCT_W-1:0]  pct;
    } light_t;

    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 20;
    localparam int DAY_ITEMS     = 250;
    localparam int DAY_PHASES    = 8;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_DAWN_START;
    logic [CFG_DAT_W-1:0]  cfg_wdata = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [M_DATA_W-1:0]   m_tdata;

    // local copy of the window registers
    logic [MINUTE_W-1:0] rise_begin_r = RST_DAWN_START;
    logic [MINUTE_W-1:0] rise_done_r  = RST_DAWN_END;
    logic [MINUTE_W-1:0] fall_begin_r = RST_DUSK_START;
    logic [MINUTE_W-1:0] fall_done_r  = RST_DUSK_END;
    logic [RELAY_W-1:0]  relays_r     = RST_RELAYS;

    light_t light_q[$];
    int     errors       = 0;
    int     minutes_sent = 0;
    int     results_seen = 0;
    int     reg_writes   = 0;
    int     quiet_cycles = 0;
    int     mode_hits[4] = '{0, 0, 0, 0};

    int     tx_max_gap    = 0;
    int     tx_burst_left = 0;
    int     rx_max_stall  = 0;
    int     rx_run        = 0;
    bit     rx_ready_state = 1'b0;

    dawn_dusk_light_ramp_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic light_t calc_light_level(input logic [MINUTE_W-1:0] minute,
                                                output mode_t mode);
        int unsigned now;
        int unsigned n;
        int unsigned num;
        int unsigned den;
        int unsigned active;
        int unsigned pct;
        light_t      res;
        now    = minute;
        n      = relays_r;
        active = 0;
        pct    = 0;
        if (n == 0 || n > MAX_RELAYS) n = MAX_RELAYS;
        if (now < rise_begin_r || now >= fall_done_r) begin
            mode = MODE_OFF;
        end else if (now >= rise_done_r && now < fall_begin_r) begin
            mode   = MODE_FULL;
            active = n;
            pct    = 100;
        end else if (now < rise_done_r) begin
            mode   = MODE_DAWN;
            num    = now - rise_begin_r;
            den    = rise_done_r - rise_begin_r;
            active = (n * num + den - 1) / den;
            if (active > n) active = n;
            pct    = (200 * num + den) / (2 * den);
        end else begin
            mode   = MODE_DUSK;
            num    = now - fall_begin_r;
            den    = fall_done_r - fall_begin_r;
            active = (n * num + den - 1) / den;
            active = (active >= n) ? 0 : n - active;
            pct    = (200 * (den - num) + den) / (2 * den);
        end
        if (pct > 100) pct = 100;
        if (active > 31) active = 31;
        res.mask = MASK_W'((32'd1 << active) - 32'd1);
        res.pct  = PCT_W'(pct);
        return res;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] value);
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wen <= 1'b0;
        case (idx)
            CFG_DAWN_START: rise_begin_r = value[MINUTE_W-1:0];
            CFG_DAWN_END:   rise_done_r  = value[MINUTE_W-1:0];
            CFG_DUSK_START: fall_begin_r = value[MINUTE_W-1:0];
            CFG_DUSK_END:   fall_done_r  = value[MINUTE_W-1:0];
            CFG_RELAYS:     relays_r     = value[RELAY_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic write_windows(input int unsigned ds, input int unsigned de,
                                 input int unsigned ks, input int unsigned ke,
                                 input int unsigned relays);
        write_reg(CFG_DAWN_START, CFG_DAT_W'(ds));
        write_reg(CFG_DAWN_END,   CFG_DAT_W'(de));
        write_reg(CFG_DUSK_START, CFG_DAT_W'(ks));
        write_reg(CFG_DUSK_END,   CFG_DAT_W'(ke));
        write_reg(CFG_RELAYS,     CFG_DAT_W'(relays));
    endtask

    task automatic send_minute(input logic [MINUTE_W-1:0] minute);
        mode_t  mode;
        light_t want;
        int     gap;
        if (tx_burst_left == 0) begin
            gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            tx_burst_left = $urandom_range(1, 24);
        end
        tx_burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(minute);
        do @(posedge aclk); while (!s_tready);
        want = calc_light_level(minute, mode);
        light_q.push_back(want);
        mode_hits[mode]++;
        minutes_sent++;
    endtask

    // drop valid and hold until the pipeline has delivered everything
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (light_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [MINUTE_W-1:0] pick_minute();
        int unsigned sel;
        int          base;
        sel = $urandom_range(0, 19);
        if (sel < 9) begin
            case ($urandom_range(0, 3))
                0:       base = rise_begin_r;
                1:       base = rise_done_r;
                2:       base = fall_begin_r;
                default: base = fall_done_r;
            endcase
            base = base + $urandom_range(0, 6) - 3;
            return MINUTE_W'(base & 32'h7FF);
        end else if (sel < 17) begin
            return MINUTE_W'($urandom_range(0, 1439));
        end
        return MINUTE_W'($urandom_range(0, 2047));
    endfunction

    task automatic randomize_windows(input int kind, input int unsigned relays);
        int unsigned e[4];
        int unsigned t;
        int          i;
        int          j;
        for (i = 0; i < 4; i++) begin
            case (kind)
                1: e[i] = $urandom_range(0, 2047);
                2: begin
                    case ($urandom_range(0, 4))
                        0:       e[i] = 0;
                        1:       e[i] = 1;
                        2:       e[i] = 1439;
                        3:       e[i] = 1440;
                        default: e[i] = 2047;
                    endcase
                end
                default: e[i] = $urandom_range(0, 1440);
            endcase
        end
        if (kind == 0 || kind == 3) begin
            for (i = 0; i < 3; i++) begin
                for (j = 0; j < 3 - i; j++) begin
                    if (e[j] > e[j + 1]) begin
                        t        = e[j];
                        e[j]     = e[j + 1];
                        e[j + 1] = t;
                    end
                end
            end
        end
        // empty one of the ramps
        if (kind == 3) begin
            if ($urandom_range(0, 1)) e[1] = e[0];
            else e[3] = e[2];
        end
        write_windows(e[0], e[1], e[2], e[3], relays);
    endtask

    task automatic test_default_windows();
        int unsigned minutes[14] = '{0, 359, 360, 361, 389, 390, 419, 420,
                                     1199, 1200, 1259, 1260, 1439, 2047};
        foreach (minutes[i]) send_minute(MINUTE_W'(minutes[i]));
        wait_drained();
    endtask

    task automatic test_odd_windows();
        int unsigned crossed[5] = '{550, 600, 650, 699, 700};
        int unsigned widest[4]  = '{0, 1, 2046, 2047};
        // empty dawn, dusk starting before dawn ends, zero relay setting
        write_windows(600, 600, 500, 700, 0);
        foreach (crossed[i]) send_minute(MINUTE_W'(crossed[i]));
        wait_drained();
        // full-range dawn, empty dusk at the top, oversized relay setting
        write_windows(0, 2047, 2047, 2047, 255);
        foreach (widest[i]) send_minute(MINUTE_W'(widest[i]));
        wait_drained();
    endtask

    task automatic test_random_days();
        int unsigned relay_choices[DAY_PHASES] = '{1, 2, 3, 0, 4, 5, 255, 8};
        int          phase;
        int          i;
        for (phase = 0; phase < DAY_PHASES; phase++) begin
            case (phase)
                0:       begin tx_max_gap = 0;  rx_max_stall = 0;  end
                7:       begin tx_max_gap = 10; rx_max_stall = 16; end
                default: begin
                    tx_max_gap   = $urandom_range(0, 6);
                    rx_max_stall = $urandom_range(0, 8);
                end
            endcase
            randomize_windows(phase % 4, relay_choices[phase]);
            for (i = 0; i < DAY_ITEMS; i++) begin
                send_minute(pick_minute());
                if (phase == 3 && i == DAY_ITEMS / 2) wait_drained();
            end
            wait_drained();
        end
    endtask

    // sink: always ready when rx_max_stall is zero, else alternating ready and stall runs
    always @(negedge aclk) begin
        if (rx_max_stall == 0) begin
            m_tready <= 1'b1;
        end else begin
            if (rx_run == 0) begin
                rx_ready_state = !rx_ready_state;
                rx_run = rx_ready_state ? $urandom_range(1, 12)
                                        : $urandom_range(1, rx_max_stall);
            end
            rx_run--;
            m_tready <= rx_ready_state;
        end
    end

    always @(posedge aclk) begin
        light_t got;
        light_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
                $display("** dawn_dusk_light_ramp_top: FAILED **");
                $finish;
            end else if (m_tvalid && m_tready) begin
                got.mask = m_tdata[MASK_W-1:0];
                got.pct  = m_tdata[MASK_W+PCT_W-1:MASK_W];
                results_seen++;
                if (light_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected item, actual mask %h pct %0d",
                             $time, got.mask, got.pct);
                end else begin
                    want = light_q.pop_front();
                    if (got.mask !== want.mask) begin
                        errors++;
                        if (errors < 40)
                            $display("%0t: relay_mask expected %h actual %h",
                                     $time, want.mask, got.mask);
                    end
                    if (got.pct !== want.pct) begin
                        errors++;
                        if (errors < 40)
                            $display("%0t: brightness_percent expected %0d actual %0d",
                                     $time, want.pct, got.pct);
                    end
                end
            end
        end
    end

    initial begin
        repeat (9) @(negedge aclk);
        aresetn      <= 1'b1;
        tx_max_gap   = 3;
        rx_max_stall = 4;
        test_default_windows();
        test_odd_windows();
        test_random_days();
        wait_drained();
        $display("sent %0d minutes: %0d off, %0d full, %0d dawn, %0d dusk",
                 minutes_sent, mode_hits[MODE_OFF], mode_hits[MODE_FULL],
                 mode_hits[MODE_DAWN], mode_hits[MODE_DUSK]);
        $display("checked %0d results over %0d register writes, %0d mismatches",
                 results_seen, reg_writes, errors);
        if (errors == 0 && light_q.size() == 0) begin
            $display("** dawn_dusk_light_ramp_top: PASSED **");
        end else begin
            $display("** dawn_dusk_light_ramp_top: FAILED **");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/ddlr_pkg.sv
rtl/ddlr_front.sv
rtl/ddlr_cell.sv
rtl/ddlr_back.sv
rtl/dawn_dusk_light_ramp_top.sv
tb/tb_dawn_dusk_light_ramp_top.sv
